[sv/pkf_pkg.sv]
// Shared types and constants for the three-axis pose Kalman filter.
// No dependencies; used by pkf_axis, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package pkf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgAddrW = 2;

  // Register map of the write port
  typedef enum logic [CfgAddrW-1:0] {
    CFG_CONTROL_GAIN  = 2'd0,
    CFG_PROCESS_NOISE = 2'd1,
    CFG_MEAS_NOISE    = 2'd2
  } pkf_cfg_addr_e;

  typedef struct packed {
    logic signed [DataW-1:0] lin_vel;
    logic signed [DataW-1:0] ang_vel;
    logic signed [DataW-1:0] meas_x;
    logic signed [DataW-1:0] meas_y;
    logic signed [DataW-1:0] meas_heading;
  } pkf_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] est_x;
    logic signed [DataW-1:0] est_y;
    logic signed [DataW-1:0] est_heading;
    logic        [DataW-1:0] var_x;
    logic        [DataW-1:0] var_y;
    logic        [DataW-1:0] var_heading;
  } pkf_out_t;

  typedef struct packed {
    logic [DataW-1:0] control_gain;
    logic [DataW-1:0] process_noise;
    logic [DataW-1:0] meas_noise;
  } pkf_cfg_t;

  // Top-level word sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } pkf_state_e;

  // Per-axis sequencer
  typedef enum logic [2:0] {
    AX_IDLE,
    AX_PREP,
    AX_PRED,
    AX_SAT,
    AX_INNOV,
    AX_CORR,
    AX_FIN
  } pkf_axis_state_e;

endpackage

[sv/pkf_axis.sv]
// One scalar Kalman filter lane: bit-serial multiply units and a
// bit-serial restoring divider, driven by a small sequencer. Uses pkf_pkg.
`timescale 1ns / 1ps

module pkf_axis #(
  parameter int unsigned FRAC_BITS = 16,
  parameter logic [31:0] EST_RESET = 32'h0000_0000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [pkf_pkg::DataW-1:0] u_i,
  input  logic signed [pkf_pkg::DataW-1:0] meas_i,
  input  pkf_pkg::pkf_cfg_t                cfg_i,
  output logic                             done_o,
  output logic signed [pkf_pkg::DataW-1:0] est_o,
  output logic        [pkf_pkg::DataW-1:0] var_o
);
  import pkf_pkg::*;

  localparam int unsigned KW    = FRAC_BITS + 1;            // gain width, 1.0 included
  localparam int unsigned MulW  = DataW + 2;                // serial multiplicand
  localparam int unsigned CntW  = $clog2(DataW);
  localparam int unsigned RemW  = DataW + 1;
  localparam int unsigned TermW = MulW + DataW - FRAC_BITS;
  localparam int unsigned PredW = TermW + 1;
  localparam int unsigned CorW  = MulW + 2;
  localparam logic [KW-1:0]   One      = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CntW-1:0] CntLast  = CntW'(DataW - 1);
  localparam logic [CntW-1:0] CntKLast = CntW'(KW - 1);
  localparam logic [CntW-1:0] CntK     = CntW'(KW);

  pkf_axis_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;

  logic signed [DataW-1:0] u_q, meas_q, pred_q, est_q;
  logic        [DataW-1:0] pv_q, var_q, loa_q, lob_q;
  logic        [RemW-1:0]  den_q, rem_q;
  logic        [KW-1:0]    quo_q, k_q;
  logic signed [MulW-1:0]  innov_q, hia_q, hib_q;

  // serial multiply datapaths
  logic signed [MulW-1:0] opa;
  logic        [MulW-1:0] opb;
  logic        [MulW:0]   suma, sumb;
  // divider step
  logic                   fbit;
  logic        [RemW:0]   rem2, den_ext, rem_diff;
  logic                   rem_ge;
  // prediction / correction sums
  logic        [DataW:0]  pv_sum;
  logic        [DataW-1:0] pv_sat;
  logic        [TermW-1:0] term;
  logic        [PredW-1:0] pred_sum;
  logic        [MulW:0]    cterm;
  logic        [CorW-1:0]  cor_sum;
  logic        [DataW-1:0] var_new;

  function automatic logic [DataW-1:0] sat_data(input logic [PredW-1:0] v);
    logic [DataW-1:0] r;
    if (&v[PredW-1:DataW-1] || ~|v[PredW-1:DataW-1]) begin
      r = v[DataW-1:0];
    end else if (v[PredW-1]) begin
      r = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

  assign opa  = (state_q == AX_CORR) ? innov_q : MulW'(u_q);
  assign opb  = {2'b00, pv_q};
  assign suma = {hia_q[MulW-1], hia_q} + (loa_q[0] ? {opa[MulW-1], opa} : '0);
  assign sumb = {hib_q[MulW-1], hib_q} + (lob_q[0] ? {1'b0, opb} : '0);

  // dividend is pv << FRAC_BITS; its top part is preloaded, pv[0] then zeros feed in
  assign fbit     = (cnt_q == '0) ? pv_q[0] : 1'b0;
  assign rem2     = {rem_q, fbit};
  assign den_ext  = {1'b0, den_q};
  assign rem_ge   = (rem2 >= den_ext);
  assign rem_diff = rem2 - den_ext;

  assign pv_sum   = {1'b0, var_q} + {1'b0, cfg_i.process_noise};
  assign pv_sat   = pv_sum[DataW] ? '1 : pv_sum[DataW-1:0];

  assign term     = {hia_q, loa_q[DataW-1:FRAC_BITS]};
  assign pred_sum = {{(PredW-DataW){est_q[DataW-1]}}, est_q} + {term[TermW-1], term};

  // after KW steps, product bit FRAC_BITS sits in lo[MSB]
  assign cterm    = {hia_q, loa_q[DataW-1]};
  assign cor_sum  = {{(CorW-DataW){pred_q[DataW-1]}}, pred_q} + {cterm[MulW], cterm};
  assign var_new  = {hib_q[DataW-2:0], lob_q[DataW-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    done_d  = 1'b0;
    case (state_q)
      AX_IDLE: begin
        if (start_i) state_d = AX_PREP;
      end
      AX_PREP:  state_d = AX_PRED;
      AX_PRED: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) state_d = AX_SAT;
      end
      AX_SAT:   state_d = AX_INNOV;
      AX_INNOV: state_d = AX_CORR;
      AX_CORR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntKLast) state_d = AX_FIN;
      end
      AX_FIN: begin
        done_d  = 1'b1;
        state_d = AX_IDLE;
      end
      default: state_d = AX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AX_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= EST_RESET;
      var_q <= DataW'(One);
    end else if (state_q == AX_FIN) begin
      est_q <= sat_data(PredW'($signed(cor_sum)));
      var_q <= var_new;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      AX_IDLE: begin
        if (start_i) begin
          u_q    <= u_i;
          meas_q <= meas_i;
          pv_q   <= pv_sat;
        end
      end
      AX_PREP: begin
        den_q <= {1'b0, pv_q} + {1'b0, cfg_i.meas_noise};
        rem_q <= RemW'(pv_q >> 1);
        quo_q <= '0;
        hia_q <= '0;
        loa_q <= cfg_i.control_gain;
      end
      AX_PRED: begin
        hia_q <= suma[MulW:1];
        loa_q <= {suma[0], loa_q[DataW-1:1]};
        if (cnt_q < CntK) begin
          if (rem_ge) begin
            rem_q <= rem_diff[RemW-1:0];
            quo_q <= {quo_q[KW-2:0], 1'b1};
          end else begin
            rem_q <= rem2[RemW-1:0];
            quo_q <= {quo_q[KW-2:0], 1'b0};
          end
        end
      end
      AX_SAT: begin
        pred_q <= sat_data(pred_sum);
        k_q    <= (den_q == '0) ? One : quo_q;
      end
      AX_INNOV: begin
        innov_q <= {{(MulW-DataW){meas_q[DataW-1]}}, meas_q}
                 - {{(MulW-DataW){pred_q[DataW-1]}}, pred_q};
        hia_q   <= '0;
        hib_q   <= '0;
        loa_q   <= DataW'(k_q);
        lob_q   <= DataW'(One - k_q);
      end
      AX_CORR: begin
        hia_q <= suma[MulW:1];
        loa_q <= {suma[0], loa_q[DataW-1:1]};
        hib_q <= sumb[MulW:1];
        lob_q <= {sumb[0], lob_q[DataW-1:1]};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign est_o  = est_q;
  assign var_o  = var_q;

endmodule

[sv/pose_kalman_filter_3axis.sv]
// Three-axis pose Kalman filter top level: register port, word handshake,
// output register and three pkf_axis lanes. Uses pkf_pkg and pkf_axis.
//
//   channel | handshake            | word
//   --------+----------------------+--------------------------------------------
//   in      | in_valid_i/in_stall_o | pkf_in_t: velocities and measured pose
//   out     | out_valid_o/out_stall_i | pkf_out_t: estimates and variances
//   cfg     | cfg_we_i              | cfg_addr_i selects, cfg_wdata_i is written
//
// Flow: an accepted word runs through the lanes and is loaded into the output
//   register; the next word can be accepted in the same cycle as that result
//   appears, so words go one at a time. A run is the 32-step serial product b*u,
//   with the FRAC_BITS+1-step gain division beside it, then the FRAC_BITS+1-step
//   gain products; FRAC_BITS is 16 for Q16.16. All three axes run side by side.
// Reset: estimates x 0, y 0, heading 1.0; variances 1.0; registers 0.05, 0.03
//   and 0.01 in fixed point.
// Stalls: in_stall_o is high from acceptance until the result is loaded into
//   the output register. A stalled output word holds; a new word may still be
//   accepted behind it, and its result waits until the register frees up.
`timescale 1ns / 1ps

module pose_kalman_filter_3axis #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pkf_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [pkf_pkg::DataW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pkf_pkg::pkf_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pkf_pkg::pkf_out_t                out_data_o
);
  import pkf_pkg::*;

  // Reset values: hundredths scaled by 2^FRAC_BITS, rounded to nearest
  localparam logic [DataW-1:0] CtlGainRst =
    DataW'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [DataW-1:0] ProcNoiseRst =
    DataW'(((64'd3 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [DataW-1:0] MeasNoiseRst =
    DataW'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [DataW-1:0] HeadingRst = DataW'(64'd1 << FRAC_BITS);

  pkf_cfg_t   cfg_q;
  pkf_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  pkf_out_t   out_q;

  logic              accept;
  logic              load_out;
  logic              all_done;
  logic [2:0]        lane_done;
  logic signed [DataW-1:0] est_x, est_y, est_hd;
  logic        [DataW-1:0] var_x, var_y, var_hd;

  // ------------------------------------------------------------------
  // Register port; unknown indexes are dropped
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_gain  <= CtlGainRst;
      cfg_q.process_noise <= ProcNoiseRst;
      cfg_q.meas_noise    <= MeasNoiseRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_CONTROL_GAIN:  cfg_q.control_gain  <= cfg_wdata_i;
        CFG_PROCESS_NOISE: cfg_q.process_noise <= cfg_wdata_i;
        CFG_MEAS_NOISE:    cfg_q.meas_noise    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Lanes: x driven by linear velocity, y undriven, heading by angular
  // ------------------------------------------------------------------
  pkf_axis #(
    .FRAC_BITS (FRAC_BITS),
    .EST_RESET ('0)
  ) u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .u_i     (in_data_i.lin_vel),
    .meas_i  (in_data_i.meas_x),
    .cfg_i   (cfg_q),
    .done_o  (lane_done[0]),
    .est_o   (est_x),
    .var_o   (var_x)
  );

  pkf_axis #(
    .FRAC_BITS (FRAC_BITS),
    .EST_RESET ('0)
  ) u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .u_i     ('0),
    .meas_i  (in_data_i.meas_y),
    .cfg_i   (cfg_q),
    .done_o  (lane_done[1]),
    .est_o   (est_y),
    .var_o   (var_y)
  );

  pkf_axis #(
    .FRAC_BITS (FRAC_BITS),
    .EST_RESET (HeadingRst)
  ) u_axis_hd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .u_i     (in_data_i.ang_vel),
    .meas_i  (in_data_i.meas_heading),
    .cfg_i   (cfg_q),
    .done_o  (lane_done[2]),
    .est_o   (est_hd),
    .var_o   (var_hd)
  );

  // lanes run in lockstep, so their done pulses coincide
  assign all_done = &lane_done;

  // ------------------------------------------------------------------
  // Word sequencing
  // ------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (all_done) begin
          // output register free, or its word leaves at this edge
          if (!out_valid_q || !out_stall_i) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d  = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // lane state is stable until the next word is accepted
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.est_x       <= est_x;
      out_q.est_y       <= est_y;
      out_q.est_heading <= est_hd;
      out_q.var_x       <= var_x;
      out_q.var_y       <= var_y;
      out_q.var_heading <= var_hd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/pkf_checker.sv]
// Port-level checker for pose_kalman_filter_3axis and its bind statement.
// Uses pkf_pkg for the output word type.
`timescale 1ns / 1ps

module pkf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pkf_pkg::pkf_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after a word was accepted");

  a_word_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("new output word without input released");

  a_release_with_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input released without a result word");

endmodule

bind pose_kalman_filter_3axis pkf_checker u_pkf_checker (.*);

[tb/pose_kalman_filter_3axis_test.sv]
// Self-checking testbench for pose_kalman_filter_3axis: a queue-fed driver and a monitor
// that checks each output word against a bit-true fixed-point filter model.
// Depends on pkf_pkg and the pose_kalman_filter_3axis RTL only.
`timescale 1ns / 1ps

module pose_kalman_filter_3axis_test;
  import pkf_pkg::*;

  localparam int FracBits     = 16;
  localparam int PhaseCount   = 12;
  localparam int PhaseWords   = 165;
  localparam int SettleCycles = FracBits + 40;   // output latency plus margin
  localparam int LongHold     = 1500;            // receiver hold-off, cycles
  localparam longint MaxS32   = 64'sd2147483647;
  localparam longint MinS32   = -64'sd2147483648;
  localparam longint unsigned One = 64'd1 << FracBits;
  // index 3 is not mapped; a write there must be dropped
  localparam logic [CfgAddrW-1:0] CfgUnmapped = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [DataW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pkf_in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pkf_out_t out_word;

  pose_kalman_filter_3axis #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Filter model: own copy of registers and per-axis state
  // ---------------------------------------------------------------------------
  logic [31:0] ctl_gain, proc_noise, meas_noise;
  logic signed [31:0] pose_est [3];
  logic [31:0] pose_var [3];

  pkf_in_t  cmd_meas_q [$];   // words waiting to be offered
  pkf_out_t filtered_q [$];   // filtered poses waiting to come out
  int errors = 0;

  // run-time knobs, written by the sequencer at negedge only
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int hold_asks = 0;

  function automatic void queue_cmd(pkf_in_t w);
    cmd_meas_q.insert(cmd_meas_q.size(), w);
  endfunction

  function automatic void queue_pose(pkf_out_t p);
    filtered_q.insert(filtered_q.size(), p);
  endfunction

  function automatic logic signed [31:0] sat32(longint signed v);
    if (v > MaxS32) return 32'sh7FFFFFFF;
    if (v < MinS32) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic void pose_reset();
    ctl_gain    = 32'(((64'd5 << FracBits) + 50) / 100);
    proc_noise  = 32'(((64'd3 << FracBits) + 50) / 100);
    meas_noise  = 32'(((64'd1 << FracBits) + 50) / 100);
    pose_est[0] = '0;
    pose_est[1] = '0;
    pose_est[2] = 32'(One);
    for (int i = 0; i < 3; i++) pose_var[i] = 32'(One);
  endfunction

  // One scalar Kalman update on a single axis
  function automatic void axis_update(int ax, logic signed [31:0] u, logic signed [31:0] meas);
    longint signed drift, pred, innov;
    longint unsigned pv, denom, gain;
    drift = (longint'(ctl_gain) * longint'(u)) >>> FracBits;
    pred  = longint'(sat32(longint'(pose_est[ax]) + drift));
    pv    = 64'(pose_var[ax]) + 64'(proc_noise);
    if (pv > 64'hFFFF_FFFF) pv = 64'hFFFF_FFFF;
    denom = pv + 64'(meas_noise);
    // zero denominator means full trust in the measurement
    if (denom == 0) gain = One;
    else gain = (pv << FracBits) / denom;
    if (gain > One) gain = One;
    innov = longint'(meas) - pred;
    pose_est[ax] = sat32(pred + ((longint'(gain) * innov) >>> FracBits));
    pose_var[ax] = 32'(((One - gain) * pv) >> FracBits);
  endfunction

  function automatic pkf_out_t filter_step(pkf_in_t w);
    pkf_out_t r;
    axis_update(0, w.lin_vel, w.meas_x);
    axis_update(1, '0, w.meas_y);       // no control input on y
    axis_update(2, w.ang_vel, w.meas_heading);
    r.est_x       = pose_est[0];
    r.est_y       = pose_est[1];
    r.est_heading = pose_est[2];
    r.var_x       = pose_var[0];
    r.var_y       = pose_var[1];
    r.var_heading = pose_var[2];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers words from cmd_meas_q, predicts on acceptance
  // ---------------------------------------------------------------------------
  int send_gap;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) queue_pose(filter_step(in_word));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_meas_q.size() > 0) begin
          in_word  <= cmd_meas_q.pop_front();
          in_valid <= 1'b1;
          send_gap = send_gaps ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks output words, drives random and long stalls
  // ---------------------------------------------------------------------------
  int hold_seen, hold_left, stall_left;
  pkf_out_t want_w, got_w;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_w = out_word;
        if (filtered_q.size() == 0) begin
          $error("output word with no prediction pending: %h", got_w);
          errors++;
        end else begin
          want_w = filtered_q.pop_front();
          check_field("est_x", want_w.est_x, got_w.est_x);
          check_field("est_y", want_w.est_y, got_w.est_y);
          check_field("est_heading", want_w.est_heading, got_w.est_heading);
          check_field("var_x", want_w.var_x, got_w.var_x);
          check_field("var_y", want_w.var_y, got_w.var_y);
          check_field("var_heading", want_w.var_heading, got_w.var_heading);
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (recv_gaps && $urandom_range(0, 99) < 25) begin
        stall_left = gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [CfgAddrW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CONTROL_GAIN:  ctl_gain = val;
      CFG_PROCESS_NOISE: proc_noise = val;
      CFG_MEAS_NOISE:    meas_noise = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [31:0] b, logic [31:0] r, logic [31:0] q);
    reg_write(CFG_CONTROL_GAIN, b);
    reg_write(CFG_PROCESS_NOISE, r);
    reg_write(CFG_MEAS_NOISE, q);
  endtask

  // Wait for every word to come back, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    while (cmd_meas_q.size() != 0 || in_valid || filtered_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic pkf_in_t mk_word(logic [31:0] lin, logic [31:0] ang, logic [31:0] mx,
                                      logic [31:0] my, logic [31:0] mh);
    pkf_in_t w;
    w.lin_vel      = lin;
    w.ang_vel      = ang;
    w.meas_x       = mx;
    w.meas_y       = my;
    w.meas_heading = mh;
    return w;
  endfunction

  function automatic logic [31:0] rand_field();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return $urandom();
    if (p < 75) return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
    if (p < 87) return 32'h7FFF_FFFF - 32'($urandom_range(0, 255));
    return 32'h8000_0000 + 32'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] rand_reg();
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) return $urandom_range(0, 32'h0002_0000);
    if (p < 55) return $urandom_range(0, 32'h0000_1000);
    if (p < 75) return $urandom();
    if (p < 85) return '0;
    return 32'hFFFF_FFFF - 32'($urandom_range(0, 65535));
  endfunction

  initial begin
    pose_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at reset register values: field extremes and bit patterns
    queue_cmd(mk_word('0, '0, '0, '0, '0));
    queue_cmd(mk_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_cmd(mk_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000));
    queue_cmd(mk_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, '0));
    queue_cmd(mk_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000));
    queue_cmd(mk_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'h5555_5555));
    queue_cmd(mk_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                      32'h5555_5555, 32'hAAAA_AAAA));
    queue_cmd(mk_word('1, '1, '1, '1, '1));
    queue_cmd(mk_word(32'd1, 32'd1, 32'd1, 32'd1, 32'd1));
    queue_cmd(mk_word(32'(One), 32'(One), 32'(One), 32'(One), 32'(One)));
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      send_gaps = (ph % 3 != 1);
      recv_gaps = (ph % 4 != 2);
      case (ph)
        // zero noise: gain pinned at one, then the zero-denominator case
        0: set_regs('0, '0, '0);
        // saturated predicted variance and estimate
        1: set_regs('1, '1, '1);
        // huge control gain with exact measurements
        2: set_regs(32'hFFFF_FFFF, '0, '0);
        3: begin
          set_regs(rand_reg(), rand_reg(), rand_reg());
          reg_write(CfgUnmapped, $urandom());
        end
        default: set_regs(rand_reg(), rand_reg(), rand_reg());
      endcase

      if (ph == 0 || ph == 1) begin
        queue_cmd(mk_word(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0));
        queue_cmd(mk_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF));
        queue_cmd(mk_word('0, '0, '0, '0, '0));
      end

      // long receiver hold-off while the sender keeps offering words
      if (ph == 4 || ph == 9) send_gaps = 1'b0;
      for (int n = 0; n < PhaseWords; n++) begin
        queue_cmd(mk_word(rand_field(), rand_field(), rand_field(),
                          rand_field(), rand_field()));
      end
      if (ph == 4 || ph == 9) begin
        while (cmd_meas_q.size() > PhaseWords - 20) @(negedge clk);
        hold_asks++;
      end
      drain();
    end

    if (filtered_q.size() != 0) begin
      $error("%0d filtered poses never came out", filtered_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("pose_kalman_filter_3axis_test: clean");
    end else begin
      $display("pose_kalman_filter_3axis_test: errors");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #80ms;
    $display("pose_kalman_filter_3axis_test: errors");
    $finish;
  end

endmodule

[pose_kalman_filter_3axis.f]
sv/pkf_pkg.sv
sv/pkf_axis.sv
sv/pose_kalman_filter_3axis.sv
sv/pkf_checker.sv
tb/pose_kalman_filter_3axis_test.sv
